// ===== design/fsde_pkg.sv =====
// shared types and constants for the flux sample to delta encoder
`timescale 1ns / 1ps
`default_nettype none

package fsde_pkg;

	// samples per input word, oldest in the top bit
	localparam int SAMPLES = 8;
	// most results one input word can queue
	localparam int MAX_RES = 6;
	// width of a result count, 0 to MAX_RES
	localparam int NRES_W = 3;
	// most timing codes one word can raise (a carry and an edge per sample)
	localparam int MAX_EV = 2 * SAMPLES;
	// width of an event count, 0 to MAX_EV
	localparam int EV_W = 5;
	// width of an event index
	localparam int EVI_W = 4;
	// length and buffer size width
	localparam int LEN_W = 24;
	// code width
	localparam int CODE_W = 8;
	// buffer size after reset
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 24'hFFFFFF;

	typedef enum logic [1:0] {
		KIND_CODE  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              level;
		logic [CODE_W-1:0] count;
		logic [LEN_W-1:0]  written;
		logic              aborted;
	} state_t;

endpackage

`default_nettype wire

// ===== design/flux_sample_to_delta_encoder.sv =====
// Flux sample to delta encoder: takes one sample word (eight read-pin samples,
// oldest in bit 7) per cycle and turns rising level edges and carry limits
// into timing code words, followed by a track length or an overflow word. A
// word is held in the input register, where all eight samples are resolved
// at once; its results (up to six) go into a QUEUE_DEPTH-entry result queue
// as it leaves the register and leave one per cycle on the output while
// out_ready is high. A new sample word is taken every cycle as long as the
// queue has room for six more results; the queue depth sets how long an
// output stall or a burst of edges can last before input stalls. The buffer
// size register is written through cfg_we / cfg_wdata and applies to every
// word resolved after the write.
`timescale 1ns / 1ps
`default_nettype none

module flux_sample_to_delta_encoder #(
	parameter int CARRY_LIMIT = 127,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fsde_pkg::LEN_W-1:0]        cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [fsde_pkg::CODE_W-1:0]       sample_byte,
	input  wire logic                              first_of_track,
	input  wire logic                              last_of_track,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0]                             result_kind,
	output logic [fsde_pkg::CODE_W-1:0]            code,
	output logic [fsde_pkg::LEN_W-1:0]             track_length,
	output logic                                   last_of_run
);

	logic                                  v_s1;
	logic [fsde_pkg::CODE_W-1:0]           smp_s1;
	logic                                  first_s1;
	logic                                  last_s1;
	logic                                  adv_s1;
	logic [fsde_pkg::LEN_W-1:0]            max_length_q;
	fsde_pkg::state_t                      st_q;
	fsde_pkg::state_t                      nxt;
	logic [fsde_pkg::NRES_W-1:0]           step_n;
	logic [fsde_pkg::NRES_W-1:0]           push_n;
	fsde_pkg::res_t [fsde_pkg::MAX_RES-1:0] step_res;
	fsde_pkg::res_t                        head;
	logic                                  q_nonempty;
	logic                                  q_space;
	logic                                  pop;

	// word leaves the input register once the queue can take a full batch
	assign adv_s1   = v_s1 && q_space;
	assign in_ready = !v_s1 || adv_s1;
	assign push_n   = adv_s1 ? step_n : '0;
	assign pop      = out_valid && out_ready;

	// buffer size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= fsde_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_s1   <= sample_byte;
			first_s1 <= first_of_track;
			last_s1  <= last_of_track;
		end
	end

	// track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			st_q <= nxt;
		end
	end

	fsde_step #(
		.CARRY_LIMIT(CARRY_LIMIT)
	) u_step (
		.smp       (smp_s1),
		.first     (first_s1),
		.last      (last_s1),
		.st        (st_q),
		.max_length(max_length_q),
		.nxt       (nxt),
		.push_n    (step_n),
		.res       (step_res)
	);

	fsde_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_data(step_res),
		.pop      (pop),
		.head     (head),
		.nonempty (q_nonempty),
		.space    (q_space)
	);

	// output word from the queue head
	assign out_valid    = q_nonempty;
	assign result_kind  = head.kind;
	assign code         = head.code;
	assign track_length = head.len;
	assign last_of_run  = head.last;

`ifndef SYNTHESIS
	// the sample counter never rests at the carry limit
	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.count < fsde_pkg::CODE_W'(CARRY_LIMIT))
		else $error("sample count reached carry limit");

	// an aborted track queues nothing until a new track starts
	a_abort_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && st_q.aborted && !first_s1) |-> (push_n == '0))
		else $error("results from aborted track");

	// abort is only raised by a word leaving the input register
	a_abort_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.aborted) |-> $past(adv_s1))
		else $error("abort without a word");
`endif

endmodule

`default_nettype wire

// ===== design/fsde_step.sv =====
// per-word encoding logic: sample walk, overflow check, result slots
`timescale 1ns / 1ps
`default_nettype none

module fsde_step #(
	parameter int CARRY_LIMIT = 127
) (
	input  wire logic [fsde_pkg::CODE_W-1:0]              smp,
	input  wire logic                                     first,
	input  wire logic                                     last,
	input  wire fsde_pkg::state_t                         st,
	input  wire logic [fsde_pkg::LEN_W-1:0]               max_length,
	output fsde_pkg::state_t                              nxt,
	output logic [fsde_pkg::NRES_W-1:0]                   push_n,
	output fsde_pkg::res_t [fsde_pkg::MAX_RES-1:0]        res
);

	localparam logic [fsde_pkg::CODE_W-1:0] LIMIT = fsde_pkg::CODE_W'(CARRY_LIMIT);

	fsde_pkg::state_t                      st_eff;
	logic                                  lvl;
	logic [fsde_pkg::CODE_W-1:0]           cnt;
	logic [fsde_pkg::EV_W-1:0]             k;
	logic [fsde_pkg::CODE_W-1:0]           ev [fsde_pkg::MAX_EV];
	logic [fsde_pkg::LEN_W:0]              d;
	logic [fsde_pkg::LEN_W:0]              rm;
	logic [fsde_pkg::EV_W-1:0]             avail;
	logic                                  ovf;
	logic [fsde_pkg::EV_W-1:0]             nwr;
	logic [fsde_pkg::EV_W-1:0]             nres;
	logic [fsde_pkg::LEN_W-1:0]            written_new;

	// start of track reloads level and clears counters and the abort flag
	always_comb begin
		st_eff = st;
		if (first) begin
			st_eff.level   = smp[fsde_pkg::SAMPLES-1];
			st_eff.count   = '0;
			st_eff.written = '0;
			st_eff.aborted = 1'b0;
		end
	end

	// walk the eight samples, oldest first, collecting timing codes
	always_comb begin
		lvl = st_eff.level;
		cnt = st_eff.count;
		k   = '0;
		for (int e = 0; e < fsde_pkg::MAX_EV; e++) begin
			ev[e] = '0;
		end
		for (int b = fsde_pkg::SAMPLES - 1; b >= 0; b--) begin
			cnt = cnt + 1'b1;
			if (cnt == LIMIT) begin
				ev[k[fsde_pkg::EVI_W-1:0]] = LIMIT;
				k   = k + 1'b1;
				cnt = '0;
			end
			if (smp[b] != lvl) begin
				lvl = smp[b];
				if (smp[b]) begin
					ev[k[fsde_pkg::EVI_W-1:0]] = cnt;
					k   = k + 1'b1;
					cnt = '0;
				end
			end
		end
	end

	// room left in the buffer, clamped to what one word can use
	always_comb begin
		d  = {1'b0, max_length} - {1'b0, st_eff.written};
		rm = d - 1'b1;
		if (d[fsde_pkg::LEN_W] || (d == '0)) begin
			avail = '0;
		end else if (rm > (fsde_pkg::LEN_W + 1)'(fsde_pkg::MAX_EV)) begin
			avail = fsde_pkg::EV_W'(fsde_pkg::MAX_EV);
		end else begin
			avail = rm[fsde_pkg::EV_W-1:0];
		end
		ovf         = (k > avail);
		nwr         = ovf ? avail : k;
		written_new = st_eff.written + fsde_pkg::LEN_W'(nwr);
		nres        = nwr + fsde_pkg::EV_W'(ovf || last);
	end

	// result count and next state; an aborted track holds still
	always_comb begin
		if (st_eff.aborted) begin
			push_n = '0;
			nxt    = st_eff;
		end else begin
			if (nres > fsde_pkg::EV_W'(fsde_pkg::MAX_RES)) begin
				push_n = fsde_pkg::NRES_W'(fsde_pkg::MAX_RES);
			end else begin
				push_n = nres[fsde_pkg::NRES_W-1:0];
			end
			nxt.level   = lvl;
			nxt.count   = cnt;
			nxt.written = written_new;
			nxt.aborted = ovf;
		end
	end

	// result slots: codes, then abort or track done
	always_comb begin
		for (int i = 0; i < fsde_pkg::MAX_RES; i++) begin
			res[i].code = '0;
			res[i].len  = '0;
			if (fsde_pkg::EV_W'(i) < nwr) begin
				res[i].kind = fsde_pkg::KIND_CODE;
				res[i].code = ev[i];
			end else if (ovf) begin
				res[i].kind = fsde_pkg::KIND_ABORT;
			end else begin
				res[i].kind = fsde_pkg::KIND_DONE;
				res[i].len  = written_new;
			end
			res[i].last = (fsde_pkg::NRES_W'(i) == push_n - 1'b1);
		end
	end

endmodule

`default_nettype wire

// ===== design/fsde_queue.sv =====
// result queue taking up to six words per cycle and giving one per cycle while popped
`timescale 1ns / 1ps
`default_nettype none

module fsde_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic [fsde_pkg::NRES_W-1:0]             push_n,
	input  wire fsde_pkg::res_t [fsde_pkg::MAX_RES-1:0]  push_data,
	input  wire logic                                    pop,
	output fsde_pkg::res_t                               head,
	output logic                                         nonempty,
	output logic                                         space
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fsde_pkg::res_t     mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head     = mem[rd_ptr_q];
	assign nonempty = (count_q != '0);
	// room for a full batch of one word
	assign space    = (count_q <= CNT_W'(DEPTH - fsde_pkg::MAX_RES));

	// storage, written in order from the write pointer
	always_ff @(posedge clk) begin
		for (int i = 0; i < fsde_pkg::MAX_RES; i++) begin
			if (fsde_pkg::NRES_W'(i) < push_n) begin
				mem[PTR_W'(wr_ptr_q + PTR_W'(i))] <= push_data[i];
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	// fill count stays within the storage
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	// a push never overruns the storage
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		((CNT_W + 1)'(count_q) + (CNT_W + 1)'(push_n) - (CNT_W + 1)'(pop))
			<= (CNT_W + 1)'(DEPTH))
		else $error("queue overrun");
`endif

endmodule

`default_nettype wire
